// ===== rtl/ebod_pkg.sv =====
// Shared widths, register map, reset values and interface types of the burst onset detector.
package ebod_pkg;

    // Field widths.
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 24;
    localparam int COORD_W = 11;
    localparam int BINW_W  = 24;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_DATA_W = ((2 * COORD_W + 1 + TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((TIME_W + COUNT_W + 7) / 8) * 8;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int REG_W  = 32;
    localparam int IDX_W  = 3;

    // Register indexes (byte address is four times the index).
    localparam logic [IDX_W-1:0] REG_ROI_X_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROI_X_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROI_Y_LOW  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROI_Y_HIGH = 3'd3;
    localparam logic [IDX_W-1:0] REG_BIN_WIDTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_COUNT_TH   = 3'd5;
    localparam logic [IDX_W-1:0] REG_RISE_TH    = 3'd6;

    // Register reset values.
    localparam logic [COORD_W-1:0] ROI_X_LOW_RST  = COORD_W'(0);
    localparam logic [COORD_W-1:0] ROI_X_HIGH_RST = COORD_W'(319);
    localparam logic [COORD_W-1:0] ROI_Y_LOW_RST  = COORD_W'(0);
    localparam logic [COORD_W-1:0] ROI_Y_HIGH_RST = COORD_W'(319);
    localparam logic [BINW_W-1:0]  BIN_WIDTH_RST  = BINW_W'(5000);
    localparam logic [COUNT_W-1:0] COUNT_TH_RST   = COUNT_W'(50);
    localparam logic [COUNT_W-1:0] RISE_TH_RST    = COUNT_W'(15);

    // Input item kinds carried in s_tuser.
    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Configuration register file contents.
    typedef struct packed {
        logic [COORD_W-1:0] x_low;
        logic [COORD_W-1:0] x_high;
        logic [COORD_W-1:0] y_low;
        logic [COORD_W-1:0] y_high;
        logic [BINW_W-1:0]  bin_width;
        logic [COUNT_W-1:0] count_th;
        logic [COUNT_W-1:0] rise_th;
    } ebod_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic div_start;
    } ebod_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic need_div;
        logic div_done;
    } ebod_stat_t;

endpackage

// ===== rtl/ebod_cfg.sv =====
// Configuration register file behind the APB-style port.
module ebod_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ebod_pkg::ADDR_W-1:0]   paddr,
    input  logic [ebod_pkg::REG_W-1:0]    pwdata,
    output logic [ebod_pkg::REG_W-1:0]    prdata,
    output logic                          pready,
    output ebod_pkg::ebod_cfg_t           cfg
);

    ebod_pkg::ebod_cfg_t               cfg_reg;
    ebod_pkg::ebod_cfg_t               cfg_next;
    logic                              wr_en;
    logic [ebod_pkg::IDX_W-1:0]        idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[ebod_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                ebod_pkg::REG_ROI_X_LOW:  cfg_next.x_low     = pwdata[ebod_pkg::COORD_W-1:0];
                ebod_pkg::REG_ROI_X_HIGH: cfg_next.x_high    = pwdata[ebod_pkg::COORD_W-1:0];
                ebod_pkg::REG_ROI_Y_LOW:  cfg_next.y_low     = pwdata[ebod_pkg::COORD_W-1:0];
                ebod_pkg::REG_ROI_Y_HIGH: cfg_next.y_high    = pwdata[ebod_pkg::COORD_W-1:0];
                ebod_pkg::REG_BIN_WIDTH:  cfg_next.bin_width = pwdata[ebod_pkg::BINW_W-1:0];
                ebod_pkg::REG_COUNT_TH:   cfg_next.count_th  = pwdata[ebod_pkg::COUNT_W-1:0];
                ebod_pkg::REG_RISE_TH:    cfg_next.rise_th   = pwdata[ebod_pkg::COUNT_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_low     <= ebod_pkg::ROI_X_LOW_RST;
            cfg_reg.x_high    <= ebod_pkg::ROI_X_HIGH_RST;
            cfg_reg.y_low     <= ebod_pkg::ROI_Y_LOW_RST;
            cfg_reg.y_high    <= ebod_pkg::ROI_Y_HIGH_RST;
            cfg_reg.bin_width <= ebod_pkg::BIN_WIDTH_RST;
            cfg_reg.count_th  <= ebod_pkg::COUNT_TH_RST;
            cfg_reg.rise_th   <= ebod_pkg::RISE_TH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (idx)
            ebod_pkg::REG_ROI_X_LOW:  prdata = ebod_pkg::REG_W'(cfg_reg.x_low);
            ebod_pkg::REG_ROI_X_HIGH: prdata = ebod_pkg::REG_W'(cfg_reg.x_high);
            ebod_pkg::REG_ROI_Y_LOW:  prdata = ebod_pkg::REG_W'(cfg_reg.y_low);
            ebod_pkg::REG_ROI_Y_HIGH: prdata = ebod_pkg::REG_W'(cfg_reg.y_high);
            ebod_pkg::REG_BIN_WIDTH:  prdata = ebod_pkg::REG_W'(cfg_reg.bin_width);
            ebod_pkg::REG_COUNT_TH:   prdata = ebod_pkg::REG_W'(cfg_reg.count_th);
            ebod_pkg::REG_RISE_TH:    prdata = ebod_pkg::REG_W'(cfg_reg.rise_th);
            default:                  prdata = '0;
        endcase
    end

endmodule

// ===== rtl/ebod_div.sv =====
// Bit-serial restoring remainder unit: time difference modulo bin width.
module ebod_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ebod_pkg::TIME_W-1:0]   dividend,
    input  logic [ebod_pkg::BINW_W-1:0]   divisor,
    output logic                          done,
    output logic [ebod_pkg::BINW_W-1:0]   rem
);

    localparam int CNT_W = $clog2(ebod_pkg::TIME_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ebod_pkg::TIME_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [ebod_pkg::TIME_W-1:0]   dvd_reg, dvd_next;
    logic [ebod_pkg::BINW_W-1:0]   div_reg, div_next;
    logic [ebod_pkg::BINW_W-1:0]   rem_reg, rem_next;
    logic [ebod_pkg::BINW_W:0]     trial;

    assign done = done_reg;
    assign rem  = rem_reg;

    // One quotient bit per cycle, most significant dividend bit first.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[ebod_pkg::TIME_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[ebod_pkg::TIME_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = ebod_pkg::BINW_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[ebod_pkg::BINW_W-1:0];
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    // The partial remainder always stays below the divisor.
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < div_reg)
        else $error("remainder reached the divisor");

    // A finished remainder is never reported while a step is still pending.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done raised while busy");

endmodule

// ===== rtl/ebod_datapath.sv =====
// Datapath: region filter, bin state, burst test, remainder unit and result register.
module ebod_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ebod_pkg::ebod_cfg_t           cfg,
    input  ebod_pkg::ebod_cmd_t           cmd,
    output ebod_pkg::ebod_stat_t          stat,
    input  logic                          func,
    input  logic [ebod_pkg::COORD_W-1:0]  pixel_x,
    input  logic [ebod_pkg::COORD_W-1:0]  pixel_y,
    input  logic                          polarity,
    input  logic [ebod_pkg::TIME_W-1:0]   event_time,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // onset_time [47:0], onset_count [71:48]
    output logic [ebod_pkg::M_DATA_W-1:0] m_tdata
);

    localparam logic [ebod_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    logic                          started_reg, started_next;
    logic [ebod_pkg::TIME_W-1:0]   begin_reg, begin_next;
    logic [ebod_pkg::COUNT_W-1:0]  tally_reg, tally_next;
    logic [ebod_pkg::COUNT_W-1:0]  last_reg, last_next;
    logic                          active_reg, active_next;
    logic [ebod_pkg::TIME_W-1:0]   hold_reg, hold_next;
    logic                          ovalid_reg, ovalid_next;
    logic [ebod_pkg::TIME_W-1:0]   otime_reg, otime_next;
    logic [ebod_pkg::COUNT_W-1:0]  ocount_reg, ocount_next;

    logic [ebod_pkg::BINW_W-1:0]   bw_eff;
    logic [ebod_pkg::COUNT_W-1:0]  cth_eff;
    logic [ebod_pkg::COUNT_W-1:0]  rth_eff;
    logic                          kept;
    logic [ebod_pkg::TIME_W:0]     diff;
    logic                          late;
    logic                          past_one;
    logic                          past_two;
    logic                          burst;
    logic                          close;
    logic                          skip_many;
    logic [ebod_pkg::COUNT_W-1:0]  base;
    logic                          div_done;
    logic [ebod_pkg::BINW_W-1:0]   div_rem;

    // Zero registers act as one.
    assign bw_eff  = (cfg.bin_width == '0) ? ebod_pkg::BINW_W'(1) : cfg.bin_width;
    assign cth_eff = (cfg.count_th == '0) ? ebod_pkg::COUNT_W'(1) : cfg.count_th;
    assign rth_eff = (cfg.rise_th == '0) ? ebod_pkg::COUNT_W'(1) : cfg.rise_th;

    // Region and polarity filter.
    assign kept = (func == ebod_pkg::FUNC_EVENT) && polarity &&
                  (pixel_x >= cfg.x_low) && (pixel_x <= cfg.x_high) &&
                  (pixel_y >= cfg.y_low) && (pixel_y <= cfg.y_high);

    // Distance from the open bin's start; borrow means time went backward.
    assign diff     = {1'b0, event_time} - {1'b0, begin_reg};
    assign late     = !diff[ebod_pkg::TIME_W];
    assign past_one = late &&
        (diff[ebod_pkg::TIME_W-1:0] >= ebod_pkg::TIME_W'(bw_eff));
    assign past_two = late &&
        (diff[ebod_pkg::TIME_W-1:0] >= ebod_pkg::TIME_W'({bw_eff, 1'b0}));

    // Burst test on the open bin.
    assign burst = (tally_reg >= cth_eff) ||
                   ((tally_reg > last_reg) && ((tally_reg - last_reg) >= rth_eff));

    assign close = cmd.take &&
        (((func == ebod_pkg::FUNC_FLUSH) && (tally_reg != '0)) ||
         (kept && started_reg && past_one));
    assign skip_many = (func == ebod_pkg::FUNC_EVENT) && past_two;

    assign stat.out_free = !ovalid_reg || m_tready;
    assign stat.need_div = kept && started_reg && past_two;
    assign stat.div_done = div_done;

    // Remainder of the gap; the new bin starts that far before the event.
    ebod_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (diff[ebod_pkg::TIME_W-1:0]),
        .divisor  (bw_eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Bin state update.
    always_comb
    begin
        started_next = started_reg;
        begin_next   = begin_reg;
        tally_next   = tally_reg;
        last_next    = last_reg;
        active_next  = active_reg;
        hold_next    = hold_reg;
        ovalid_next  = ovalid_reg;
        otime_next   = otime_reg;
        ocount_next  = ocount_reg;
        base         = close ? '0 : tally_reg;

        // Result register drains on its transaction.
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        if (close)
        begin
            if (burst && !active_reg)
            begin
                ovalid_next = 1'b1;
                otime_next  = begin_reg;
                ocount_next = tally_reg;
            end
            active_next = skip_many ? 1'b0 : burst;
            last_next   = skip_many ? '0 : tally_reg;
            tally_next  = '0;
            if (!skip_many)
            begin
                begin_next = begin_reg + ebod_pkg::TIME_W'(bw_eff);
            end
        end

        if (cmd.take)
        begin
            hold_next = event_time;
            if (kept)
            begin
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    begin_next   = event_time;
                end
                tally_next = (base == COUNT_MAX) ? base : base + ebod_pkg::COUNT_W'(1);
            end
        end

        if (div_done)
        begin
            begin_next = hold_reg - ebod_pkg::TIME_W'(div_rem);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            begin_reg   <= '0;
            tally_reg   <= '0;
            last_reg    <= '0;
            active_reg  <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
            begin_reg   <= begin_next;
            tally_reg   <= tally_next;
            last_reg    <= last_next;
            active_reg  <= active_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        otime_reg  <= otime_next;
        ocount_reg <= ocount_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ebod_pkg::M_DATA_W'({ocount_reg, otime_reg});

    // An item is only taken when the result register can hold its result.
    a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> stat.out_free)
        else $error("item taken while result register full");

    // No event is counted before the first bin has started.
    a_tally_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> tally_reg == '0)
        else $error("bin count without a started bin");

endmodule

// ===== rtl/ebod_ctrl.sv =====
// Controller: input handshake and wait for the remainder unit after a multi-bin gap.
module ebod_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  ebod_pkg::ebod_stat_t    stat,
    output ebod_pkg::ebod_cmd_t     cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic state_reg, state_next;

    // Items enter only in the idle state, with room for a result.
    assign s_tready      = (state_reg == S_IDLE) && stat.out_free;
    assign cmd.take      = s_tvalid && s_tready;
    assign cmd.div_start = cmd.take && stat.need_div;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.div_start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A kept event with a multi-bin gap always hands over to the remainder unit.
    a_div_entered: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_DIV)
        else $error("remainder wait not entered");

    // The remainder unit finishes only while the controller waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == S_DIV)
        else $error("remainder finished outside wait state");

endmodule

// ===== rtl/event_burst_onset_detector_core.sv =====
// Top level of the event burst onset detector.
//
//  channel  | direction | handshake                   | contents
//  s_*      | in        | s_tvalid / s_tready         | camera event or flush
//  m_*      | out       | m_tvalid / m_tready         | burst onset time and count
//  APB      | in        | psel & penable & pwrite     | seven configuration registers
//
// An event that stays in the open bin, closes it into the next bin, or a flush
// is handled as it is taken. A kept event that skips two or more bins holds off
// new items while the bit-serial remainder unit finds the new bin start.
// Reset clears the bin state and loads the register defaults; no clearing pass.
// A result waiting on m_tready blocks new items only while it is not taken.
module event_burst_onset_detector_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pixel_x [10:0], pixel_y [21:11], polarity [22], event_time [70:23]
    input  logic [ebod_pkg::S_DATA_W-1:0] s_tdata,
    // func [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // onset_time [47:0], onset_count [71:48]
    output logic [ebod_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ebod_pkg::ADDR_W-1:0]   paddr,
    input  logic [ebod_pkg::REG_W-1:0]    pwdata,
    output logic [ebod_pkg::REG_W-1:0]    prdata,
    output logic                          pready
);

    localparam int X_LSB = 0;
    localparam int Y_LSB = X_LSB + ebod_pkg::COORD_W;
    localparam int P_LSB = Y_LSB + ebod_pkg::COORD_W;
    localparam int T_LSB = P_LSB + 1;

    ebod_pkg::ebod_cfg_t  cfg;
    ebod_pkg::ebod_cmd_t  cmd;
    ebod_pkg::ebod_stat_t stat;

    ebod_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ebod_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ebod_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat),
        .func       (s_tuser),
        .pixel_x    (s_tdata[Y_LSB-1:X_LSB]),
        .pixel_y    (s_tdata[P_LSB-1:Y_LSB]),
        .polarity   (s_tdata[P_LSB]),
        .event_time (s_tdata[T_LSB+ebod_pkg::TIME_W-1:T_LSB]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
